// ===== rtl/core/ppmfd_pkg.sv =====
// shared types and constants for the ppm frame decoder
package ppmfd_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIDTH_W    = 15;
  localparam int CHIDX_W    = 3;
  localparam int FCOUNT_W   = 4;
  localparam int FNUM_W     = 32;
  localparam int TIME_W     = 32;

  localparam logic [0:0] REG_INVERT        = 1'b0;
  localparam logic [0:0] REG_GAP_THRESHOLD = 1'b1;

  localparam logic [WIDTH_W-1:0] GAP_THRESHOLD_RESET = 15'd2500;

  typedef enum logic [2:0] {
    KIND_IGNORED   = 3'd0,
    KIND_STORED    = 3'd1,
    KIND_PUBLISHED = 3'd2,
    KIND_READ_OK   = 3'd3,
    KIND_READ_BAD  = 3'd4
  } kind_t;

  typedef struct packed {
    logic               invert;
    logic [WIDTH_W-1:0] gap_threshold;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHIDX_W-1:0]  channel_index;
    logic [WIDTH_W-1:0]  value;
    logic [FCOUNT_W-1:0] frame_count;
    logic [FNUM_W-1:0]   frame_number;
    logic                use_rdata;
  } res_t;

endpackage

// ===== rtl/core/ppmfd_ifs.sv =====
// valid/ready channel interfaces for edge/read items and results
interface ppmfd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic                           pin_level;
  logic [ppmfd_pkg::TIME_W-1:0]   time_us;
  logic [ppmfd_pkg::CHIDX_W-1:0]  read_index;

  modport source (output valid, func, pin_level, time_us, read_index, input ready);
  modport sink   (input valid, func, pin_level, time_us, read_index, output ready);
endinterface

interface ppmfd_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      kind;
  logic [ppmfd_pkg::CHIDX_W-1:0]   channel_index;
  logic [ppmfd_pkg::WIDTH_W-1:0]   value;
  logic [ppmfd_pkg::FCOUNT_W-1:0]  frame_count;
  logic [ppmfd_pkg::FNUM_W-1:0]    frame_number;

  modport source (output valid, kind, channel_index, value, frame_count, frame_number,
                  input ready);
  modport sink   (input valid, kind, channel_index, value, frame_count, frame_number,
                  output ready);
endinterface

// ===== rtl/core/ppmfd_cfg_regs.sv =====
// apb configuration registers: invert and gap threshold
module ppmfd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppmfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ppmfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output ppmfd_pkg::cfg_t                  cfg
);

  ppmfd_pkg::cfg_t cfg_r;
  logic            wr_en;
  logic [0:0]      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert        <= 1'b0;
      cfg_r.gap_threshold <= ppmfd_pkg::GAP_THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        ppmfd_pkg::REG_INVERT:        cfg_r.invert        <= pwdata[0];
        ppmfd_pkg::REG_GAP_THRESHOLD: cfg_r.gap_threshold <= pwdata[ppmfd_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ppmfd_pkg::REG_INVERT:
        prdata = ppmfd_pkg::CFG_DATA_W'(cfg_r.invert);
      ppmfd_pkg::REG_GAP_THRESHOLD:
        prdata = ppmfd_pkg::CFG_DATA_W'(cfg_r.gap_threshold);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ppm_frame_decoder_core.sv =====
// ppm frame decoder top level: edge timing, page swap and width store
// pipeline: an accepted item is registered in s1, then in the output register; either holds on back-pressure
// throughput: one item per cycle while results are taken; a store write or a read uses the single width ram port pair
// reset: rst_n synchronous, clears pages, indexes, counters, last edge time, valid flags and config registers
// the width ram itself is not cleared; only entries of the published frame are read
module ppm_frame_decoder_core #(
  parameter int CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ppmfd_in_if.sink                         in_ch,
  ppmfd_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppmfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ppmfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int IDX_W  = $clog2(CHANNELS + 1);
  localparam int DEPTH  = 2 * CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (IDX_W > ppmfd_pkg::CHIDX_W) ? IDX_W : ppmfd_pkg::CHIDX_W;

  ppmfd_pkg::cfg_t cfg;

  ppmfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [ppmfd_pkg::WIDTH_W-1:0] width_mem [DEPTH];

  logic                              wr_page_r;
  logic                              pub_page_r;
  logic [IDX_W-1:0]                  wr_idx_r;
  logic [IDX_W-1:0]                  pub_cnt_r;
  logic [ppmfd_pkg::TIME_W-1:0]      last_time_r;
  logic [ppmfd_pkg::FNUM_W-1:0]      frames_r;
  logic                              s1_valid_r;
  ppmfd_pkg::res_t                   s1_r;
  logic [ppmfd_pkg::WIDTH_W-1:0]     rdata_r;
  logic                              out_valid_r;
  ppmfd_pkg::res_t                   out_r;
  ppmfd_pkg::res_t                   out_nxt;

  logic                              accept;
  logic                              s1_move;
  logic                              active;
  logic                              full;
  logic                              publish;
  logic                              store;
  logic                              read_ok;
  logic                              mem_we;
  logic                              mem_re;
  logic [ppmfd_pkg::TIME_W-1:0]      gap;
  logic [ADDR_W-1:0]                 wr_addr;
  logic [ADDR_W-1:0]                 rd_addr;
  ppmfd_pkg::res_t                   res;

  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign accept      = in_ch.valid && in_ch.ready;

  assign gap     = in_ch.time_us - last_time_r;
  assign full    = (wr_idx_r == IDX_W'(CHANNELS));
  assign active  = !in_ch.func && (in_ch.pin_level != cfg.invert);
  assign publish = active && ((gap > ppmfd_pkg::TIME_W'(cfg.gap_threshold)) || full);
  assign store   = active && !publish;
  assign read_ok = in_ch.func
                && (CMP_W'(in_ch.read_index) < CMP_W'(pub_cnt_r))
                && (CMP_W'(in_ch.read_index) < CMP_W'(CHANNELS));

  assign mem_we  = accept && store;
  assign mem_re  = accept && read_ok;
  assign wr_addr = wr_page_r ? ADDR_W'(CHANNELS) + ADDR_W'(wr_idx_r) : ADDR_W'(wr_idx_r);
  assign rd_addr = pub_page_r ? ADDR_W'(CHANNELS) + ADDR_W'(in_ch.read_index)
                              : ADDR_W'(in_ch.read_index);

  always_comb begin
    res.kind          = ppmfd_pkg::KIND_IGNORED;
    res.channel_index = ppmfd_pkg::CHIDX_W'(wr_idx_r);
    res.value         = '0;
    res.frame_count   = ppmfd_pkg::FCOUNT_W'(pub_cnt_r);
    res.frame_number  = frames_r;
    res.use_rdata     = 1'b0;
    priority if (in_ch.func) begin
      if (read_ok) begin
        res.kind = ppmfd_pkg::KIND_READ_OK;
      end else begin
        res.kind = ppmfd_pkg::KIND_READ_BAD;
      end
      res.channel_index = in_ch.read_index;
      res.use_rdata     = read_ok;
    end else if (!active) begin
      res.kind = ppmfd_pkg::KIND_IGNORED;
    end else if (publish) begin
      res.kind          = ppmfd_pkg::KIND_PUBLISHED;
      res.channel_index = '0;
      res.frame_count   = ppmfd_pkg::FCOUNT_W'(wr_idx_r);
      res.frame_number  = frames_r + 1'b1;
    end else begin
      res.kind  = ppmfd_pkg::KIND_STORED;
      res.value = gap[ppmfd_pkg::WIDTH_W-1:0];
    end
  end

  // width ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      width_mem[wr_addr] <= gap[ppmfd_pkg::WIDTH_W-1:0];
    end
    if (mem_re) begin
      rdata_r <= width_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_page_r   <= 1'b0;
      pub_page_r  <= 1'b0;
      wr_idx_r    <= '0;
      pub_cnt_r   <= '0;
      last_time_r <= '0;
      frames_r    <= '0;
    end else if (accept && active) begin
      last_time_r <= in_ch.time_us;
      if (publish) begin
        pub_page_r <= wr_page_r;
        pub_cnt_r  <= wr_idx_r;
        frames_r   <= frames_r + 1'b1;
        wr_idx_r   <= '0;
        wr_page_r  <= !wr_page_r;
      end else begin
        wr_idx_r <= wr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt       = s1_r;
    out_nxt.value = s1_r.use_rdata ? rdata_r : s1_r.value;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.channel_index = out_r.channel_index;
  assign out_ch.value         = out_r.value;
  assign out_ch.frame_count   = out_r.frame_count;
  assign out_ch.frame_number  = out_r.frame_number;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= IDX_W'(CHANNELS))
    else $error("write index past page end");

  a_page_split: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && (pub_cnt_r != '0) |-> (wr_page_r != pub_page_r))
    else $error("store write into published page");

  a_frame_inc: assert property (@(posedge clk) disable iff (!rst_n)
    accept && publish |=> frames_r == $past(frames_r) + 1'b1)
    else $error("frame number not advanced on publish");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_r) && $stable(rdata_r))
    else $error("stalled result lost");

endmodule

// ===== test/ppmfd_checker.sv =====
// ppm frame decoder checker: tracks config writes, predicts every result and compares it
module ppmfd_checker #(
  parameter int CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ppmfd_in_if                              in_mon,
  ppmfd_out_if                             out_mon,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppmfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                             pready,
  output int                               outstanding,
  output int                               errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ppmfd_pkg::kind_t                kind;
    logic [ppmfd_pkg::CHIDX_W-1:0]   chan;
    logic [ppmfd_pkg::WIDTH_W-1:0]   width;
    logic [ppmfd_pkg::FCOUNT_W-1:0]  count;
    logic [ppmfd_pkg::FNUM_W-1:0]    number;
  } decoded_t;

  logic [ppmfd_pkg::WIDTH_W-1:0] pulse_widths [2*CHANNELS];
  logic                          fill_page;
  logic                          shown_page;
  int unsigned                   fill_idx;
  int unsigned                   shown_count;
  logic [ppmfd_pkg::TIME_W-1:0]  last_edge_us;
  logic [ppmfd_pkg::FNUM_W-1:0]  frames;
  logic                          cfg_invert;
  logic [ppmfd_pkg::WIDTH_W-1:0] cfg_threshold;
  decoded_t                      expected_q [$];

  function automatic decoded_t decode_item(input logic func, input logic level,
                                           input logic [ppmfd_pkg::TIME_W-1:0] stamp,
                                           input logic [ppmfd_pkg::CHIDX_W-1:0] ridx);
    decoded_t                     r;
    logic [ppmfd_pkg::TIME_W-1:0] gap;
    r = '0;
    if (func) begin
      r.chan = ridx;
      if (ridx < shown_count && ridx < CHANNELS) begin
        r.kind  = ppmfd_pkg::KIND_READ_OK;
        r.width = pulse_widths[shown_page * CHANNELS + ridx];
      end else begin
        r.kind = ppmfd_pkg::KIND_READ_BAD;
      end
    end else if (level == cfg_invert) begin
      r.kind = ppmfd_pkg::KIND_IGNORED;
      r.chan = ppmfd_pkg::CHIDX_W'(fill_idx);
    end else begin
      gap = stamp - last_edge_us;
      last_edge_us = stamp;
      if (gap > cfg_threshold || fill_idx >= CHANNELS) begin
        shown_page  = fill_page;
        shown_count = fill_idx;
        frames      = frames + 1;
        fill_idx    = 0;
        fill_page   = ~fill_page;
        r.kind      = ppmfd_pkg::KIND_PUBLISHED;
      end else begin
        pulse_widths[fill_page * CHANNELS + fill_idx] = gap[ppmfd_pkg::WIDTH_W-1:0];
        r.kind   = ppmfd_pkg::KIND_STORED;
        r.chan   = ppmfd_pkg::CHIDX_W'(fill_idx);
        r.width  = gap[ppmfd_pkg::WIDTH_W-1:0];
        fill_idx = fill_idx + 1;
      end
    end
    r.count  = ppmfd_pkg::FCOUNT_W'(shown_count);
    r.number = frames;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("mismatch on %s: got %0d, expected %0d at %0t", name, got, want, $realtime);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      foreach (pulse_widths[i]) pulse_widths[i] = '0;
      fill_page     = 1'b0;
      shown_page    = 1'b0;
      fill_idx      = 0;
      shown_count   = 0;
      last_edge_us  = '0;
      frames        = '0;
      cfg_invert    = 1'b0;
      cfg_threshold = ppmfd_pkg::GAP_THRESHOLD_RESET;
      expected_q.delete();
      errors        = 0;
      outstanding  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ppmfd_pkg::CFG_ADDR_W-1:2])
          ppmfd_pkg::REG_INVERT:        cfg_invert = pwdata[0];
          ppmfd_pkg::REG_GAP_THRESHOLD: cfg_threshold = pwdata[ppmfd_pkg::WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          check_field("result with no transaction pending", 32'(out_mon.kind), 32'hFFFF_FFFF);
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(out_mon.kind), 32'(want.kind));
          check_field("channel_index", 32'(out_mon.channel_index), 32'(want.chan));
          check_field("value", 32'(out_mon.value), 32'(want.width));
          check_field("frame_count", 32'(out_mon.frame_count), 32'(want.count));
          check_field("frame_number", out_mon.frame_number, want.number);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(decode_item(in_mon.func, in_mon.pin_level, in_mon.time_us,
                                         in_mon.read_index));
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ppm frame decoder testbench top: clock, reset, config writes, edge and read stimulus, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS       = 8;
  localparam int PHASES         = 6;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [ppmfd_pkg::CFG_ADDR_W-1:0]     paddr = '0;
  logic [ppmfd_pkg::CFG_DATA_W-1:0]     pwdata = '0;
  logic [ppmfd_pkg::CFG_DATA_W-1:0]     prdata;
  logic                                 pready;
  int                                   outstanding;
  int                                   errors;

  logic                                 cur_invert = 1'b0;
  logic [ppmfd_pkg::WIDTH_W-1:0]        cur_threshold = ppmfd_pkg::GAP_THRESHOLD_RESET;
  logic [ppmfd_pkg::TIME_W-1:0]         last_active = '0;
  bit                                   calm = 1'b0;
  int                                   items_sent = 0;
  int                                   cycles = 0;
  int                                   quiet = 0;

  bit                                   invert_list [PHASES] = '{0, 1, 0, 1, 1, 0};
  logic [ppmfd_pkg::WIDTH_W-1:0]        threshold_list [PHASES] =
    '{15'd2500, 15'd3000, 15'd0, 15'd32767, 15'd1, 15'd2000};

  ppmfd_in_if  in_ch ();
  ppmfd_out_if out_ch ();

  ppm_frame_decoder_core #(
    .CHANNELS (CHANNELS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppmfd_checker #(
    .CHANNELS (CHANNELS)
  ) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side back-pressure in short bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && rst_n && (cycles % 300) < 200 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic func, input logic level,
                           input logic [ppmfd_pkg::TIME_W-1:0] stamp,
                           input logic [ppmfd_pkg::CHIDX_W-1:0] ridx);
    int gap;
    gap = 0;
    if (!calm && ((items_sent / 40) % 3) != 0 && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.pin_level  <= level;
    in_ch.time_us    <= stamp;
    in_ch.read_index <= ridx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_edge(input logic level, input logic [ppmfd_pkg::TIME_W-1:0] stamp);
    send_item(1'b0, level, stamp, 3'($urandom_range(0, 7)));
    if (level != cur_invert)
      last_active = stamp;
  endtask

  task automatic send_read(input logic [ppmfd_pkg::CHIDX_W-1:0] idx);
    send_item(1'b1, 1'($urandom_range(0, 1)), $urandom, idx);
  endtask

  // waits until every result is back and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ppmfd_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [ppmfd_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic inv, input logic [ppmfd_pkg::WIDTH_W-1:0] thr);
    settle();
    apb_write({ppmfd_pkg::REG_INVERT, 2'b00}, 32'(inv));
    apb_write({ppmfd_pkg::REG_GAP_THRESHOLD, 2'b00}, 32'(thr));
    cur_invert    = inv;
    cur_threshold = thr;
  endtask

  // sync gap followed by channel pulses, with inactive edges and reads mixed in
  task automatic send_frame(input int nchan);
    logic                         active;
    logic [ppmfd_pkg::TIME_W-1:0] width;
    active = ~cur_invert;
    if ($urandom_range(0, 15) == 0)
      send_edge(active, last_active + 32'h8000_0000 + $urandom_range(0, 1000));
    else
      send_edge(active, last_active + cur_threshold + $urandom_range(1, 40000));
    for (int i = 0; i < nchan; i++) begin
      case ($urandom_range(0, 9))
        0:       width = '0;
        1:       width = cur_threshold;
        default: width = $urandom_range(0, cur_threshold);
      endcase
      if ($urandom_range(0, 2) != 0)
        send_edge(~active, last_active + $urandom_range(0, width));
      send_edge(active, last_active + width);
      if ($urandom_range(0, 11) == 0)
        send_read(3'($urandom_range(0, 7)));
    end
  endtask

  task automatic random_phase(input int budget);
    int target;
    target = items_sent + budget;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: send_edge(1'($urandom_range(0, 1)), $urandom);
        1: send_edge(1'($urandom_range(0, 1)),
                     last_active + $urandom_range(0, 2 * cur_threshold + 2));
        2: send_read(3'($urandom_range(0, 7)));
        default: begin
          send_frame($urandom_range(0, CHANNELS + 1));
          repeat ($urandom_range(0, 3)) send_read(3'($urandom_range(0, 7)));
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = 1'b0;
    in_ch.pin_level  = 1'b0;
    in_ch.time_us    = '0;
    in_ch.read_index = '0;
    threshold_list[PHASES-1] = 15'($urandom_range(500, 4000));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1)
        calm = 1'b1;
      set_config(invert_list[p], threshold_list[p]);
      if (p == 0) begin
        send_read(3'd0);
        send_read(3'd7);
        send_edge(1'b0, 32'd100);
        send_edge(1'b1, 32'd5000);
        send_read(3'd0);
        send_edge(1'b1, last_active + 32'd2500);
        send_edge(1'b0, last_active + 32'd100);
        send_edge(1'b1, last_active + 32'd1);
        send_edge(1'b1, last_active);
        for (int i = 3; i < CHANNELS; i++)
          send_edge(1'b1, last_active + 32'd1000 + 32'(i * 100));
        // page full: next active edge publishes
        send_edge(1'b1, last_active + 32'd1000);
        for (int i = 0; i < CHANNELS; i++)
          send_read(3'(i));
        send_edge(1'b1, 32'hFFFF_FF00);
        send_edge(1'b1, 32'h0000_0010);
        send_edge(1'b1, last_active + 32'd2501);
        send_read(3'd0);
        send_read(3'd1);
      end
      random_phase(RANDOM_ITEMS / PHASES);
    end
    settle();
    if (errors == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ppmfd_pkg.sv
rtl/core/ppmfd_ifs.sv
rtl/core/ppmfd_cfg_regs.sv
rtl/core/ppm_frame_decoder_core.sv
test/ppmfd_checker.sv
test/testbench.sv
